>>> src/todac_pkg.sv
// Package for the time-of-day adjust and compare block.
// Holds the operation and field codes, the item structs and the ordering function.
// No dependencies.
`default_nettype none

package todac_pkg;

    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned MINS_PER_HOUR = 60;
    localparam int unsigned HOURS_PER_DAY = 24;

    localparam logic [15:0] DAYS_MAX = 16'hFFFF;

    // Operation codes.
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_SUB   = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Amount units; the remaining code acts as a zero amount.
    localparam logic [1:0] UNIT_SEC  = 2'd0;
    localparam logic [1:0] UNIT_MIN  = 2'd1;
    localparam logic [1:0] UNIT_HOUR = 2'd2;

    // Result ordering codes.
    localparam logic [1:0] ORDER_BEFORE = 2'd0;
    localparam logic [1:0] ORDER_EQUAL  = 2'd1;
    localparam logic [1:0] ORDER_AFTER  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_COMPARE_HOUR   = 2'd0;
    localparam logic [1:0] REG_COMPARE_MINUTE = 2'd1;
    localparam logic [1:0] REG_COMPARE_SECOND = 2'd2;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } todac_time_t;

    // Command fields that travel alongside the amount reduction.
    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] unit;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
    } todac_cmd_t;

    // Amount split into whole days (saturated) and a remainder in h:m:s.
    typedef struct packed {
        logic [15:0] days;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } todac_delta_t;

    function automatic logic [1:0] time_order(todac_time_t t, todac_time_t c);
        logic [1:0] result;
        if (t.hour != c.hour) begin
            result = (t.hour < c.hour) ? ORDER_BEFORE : ORDER_AFTER;
        end
        else if (t.minute != c.minute) begin
            result = (t.minute < c.minute) ? ORDER_BEFORE : ORDER_AFTER;
        end
        else if (t.second != c.second) begin
            result = (t.second < c.second) ? ORDER_BEFORE : ORDER_AFTER;
        end
        else begin
            result = ORDER_EQUAL;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

>>> src/todac_if.sv
// Channel interfaces of the time-of-day adjust and compare block:
// command, response and configuration write, each with valid and ready.
// No dependencies.
`default_nettype none

interface todac_cmd_if #(parameter int unsigned AMOUNT_BITS = 20);
    logic                   valid;
    logic                   ready;
    logic [1:0]             mode;
    logic [1:0]             unit;
    logic [AMOUNT_BITS-1:0] amount;
    logic [4:0]             load_hour;
    logic [5:0]             load_minute;
    logic [5:0]             load_second;

    modport source (output valid, mode, unit, amount, load_hour, load_minute, load_second,
                    input ready);
    modport sink   (input valid, mode, unit, amount, load_hour, load_minute, load_second,
                    output ready);
endinterface

interface todac_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] days_crossed;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
    logic [1:0]  order;

    modport source (output valid, days_crossed, now_hour, now_minute, now_second, order,
                    input ready);
    modport sink   (input valid, days_crossed, now_hour, now_minute, now_second, order,
                    output ready);
endinterface

interface todac_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [5:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/time_of_day_adjust_compare.sv
// Takes one command per cycle while no response waits on ready.
// Six stages split the amount into days and h:m:s (three constant dividers); the
// seventh stage applies it to the time with carry or borrow and registers the result.
// A response waiting on ready stalls the whole pipeline; nothing is dropped.
// Reset (rst_n low, asynchronous) empties the pipeline, sets the time to midnight and
// clears the compare time to zero. There is no clearing pass.
`default_nettype none

module time_of_day_adjust_compare
    import todac_pkg::*;
#(
    parameter int unsigned AMOUNT_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    todac_cmd_if.sink         cmd,
    todac_rsp_if.source       rsp,
    todac_cfg_if.sink         cfg
);

    logic         adv;
    logic         cmd_fire;
    todac_cmd_t   cmd_item;
    logic         step_valid;
    todac_cmd_t   step_cmd;
    todac_delta_t step_delta;

    todac_time_t  time_reg;
    todac_time_t  time_next;
    todac_time_t  compare_reg;
    logic [15:0]  days_next;
    logic [15:0]  days_reg;
    logic [1:0]   order_reg;
    logic         rsp_valid_reg;

    assign adv      = !rsp_valid_reg || rsp.ready;
    assign cmd_fire = cmd.valid && adv;
    assign cmd.ready = adv;
    assign cfg.ready = 1'b1;

    assign cmd_item = '{mode:        cmd.mode,
                        unit:        cmd.unit,
                        load_hour:   cmd.load_hour,
                        load_minute: cmd.load_minute,
                        load_second: cmd.load_second};

    todac_reduce #(.AMOUNT_BITS(AMOUNT_BITS)) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (cmd_fire),
        .in_cmd    (cmd_item),
        .in_amount (cmd.amount),
        .out_valid (step_valid),
        .out_cmd   (step_cmd),
        .out_delta (step_delta)
    );

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_COMPARE_HOUR:   compare_reg.hour   <= 5'(cfg.data);
                REG_COMPARE_MINUTE: compare_reg.minute <= cfg.data;
                REG_COMPARE_SECOND: compare_reg.second <= cfg.data;
                default:            ;
            endcase
        end
    end

    logic [6:0] sec_sum, min_sum, min_sub;
    logic [5:0] hour_sum, hour_sub;
    logic       sec_carry, min_carry, hour_carry;
    logic       sec_borrow, min_borrow, hour_borrow;
    logic       day_inc;

    // Mixed-radix add and subtract of the remainder, carry rippling through three digits.
    always_comb
    begin
        sec_sum    = 7'(time_reg.second) + 7'(step_delta.second);
        sec_carry  = (sec_sum >= 7'(SECS_PER_MIN));
        min_sum    = 7'(time_reg.minute) + 7'(step_delta.minute) + 7'(sec_carry);
        min_carry  = (min_sum >= 7'(MINS_PER_HOUR));
        hour_sum   = 6'(time_reg.hour) + 6'(step_delta.hour) + 6'(min_carry);
        hour_carry = (hour_sum >= 6'(HOURS_PER_DAY));

        sec_borrow  = (time_reg.second < step_delta.second);
        min_sub     = 7'(step_delta.minute) + 7'(sec_borrow);
        min_borrow  = (7'(time_reg.minute) < min_sub);
        hour_sub    = 6'(step_delta.hour) + 6'(min_borrow);
        hour_borrow = (6'(time_reg.hour) < hour_sub);
    end

    always_comb
    begin
        time_next = time_reg;
        day_inc   = 1'b0;
        days_next = 16'd0;
        unique case (step_cmd.mode)
            MODE_ADD:
            begin
                time_next.second = sec_carry ? 6'(sec_sum - 7'(SECS_PER_MIN)) : 6'(sec_sum);
                time_next.minute = min_carry ? 6'(min_sum - 7'(MINS_PER_HOUR)) : 6'(min_sum);
                time_next.hour   = hour_carry ? 5'(hour_sum - 6'(HOURS_PER_DAY))
                                              : 5'(hour_sum);
                day_inc = hour_carry;
            end
            MODE_SUB:
            begin
                time_next.second = 6'(7'(time_reg.second) +
                                      (sec_borrow ? 7'(SECS_PER_MIN) : 7'd0) -
                                      7'(step_delta.second));
                time_next.minute = 6'(7'(time_reg.minute) +
                                      (min_borrow ? 7'(MINS_PER_HOUR) : 7'd0) - min_sub);
                time_next.hour   = 5'(6'(time_reg.hour) +
                                      (hour_borrow ? 6'(HOURS_PER_DAY) : 6'd0) - hour_sub);
                day_inc = hour_borrow;
            end
            MODE_LOAD:
            begin
                if (step_cmd.load_hour < 5'(HOURS_PER_DAY))
                begin
                    time_next.hour = step_cmd.load_hour;
                end
                if (step_cmd.load_minute < 6'(MINS_PER_HOUR))
                begin
                    time_next.minute = step_cmd.load_minute;
                end
                if (step_cmd.load_second < 6'(SECS_PER_MIN))
                begin
                    time_next.second = step_cmd.load_second;
                end
            end
            MODE_CLEAR:
            begin
                time_next = '0;
            end
            default:
            begin
                time_next = time_reg;
            end
        endcase

        if (step_cmd.mode == MODE_ADD || step_cmd.mode == MODE_SUB)
        begin
            days_next = (step_delta.days == DAYS_MAX) ? DAYS_MAX
                                                      : step_delta.days + 16'(day_inc);
        end
    end

    // The time only moves when the response slot is free, so it doubles as the
    // response time fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= step_valid;
            if (step_valid)
            begin
                time_reg <= time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && step_valid)
        begin
            days_reg  <= days_next;
            order_reg <= time_order(time_next, compare_reg);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.days_crossed = days_reg;
    assign rsp.now_hour     = time_reg.hour;
    assign rsp.now_minute   = time_reg.minute;
    assign rsp.now_second   = time_reg.second;
    assign rsp.order        = order_reg;

endmodule

`default_nettype wire

>>> src/todac_div_const.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// Gives quotient and remainder of an unsigned value; the divisor must be at most 64.
// Depends on nothing outside this file.
`default_nettype none

module todac_div_const #(
    parameter int unsigned W       = 20,
    parameter int unsigned DIVISOR = 60
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] x,
    output logic [W-1:0] q,
    output logic [5:0]   r
);

    // floor(2^W / DIVISOR): the estimate is at most one below the true quotient.
    localparam logic [W-1:0] RECIP = W'((64'd1 << W) / DIVISOR);

    logic [2*W-1:0] prod;
    logic [W-1:0]   x_reg;
    logic [W-1:0]   qe_reg;
    logic [W+6:0]   diff;
    logic [6:0]     rem;
    logic           fix;
    logic [W-1:0]   q_reg;
    logic [5:0]     r_reg;

    assign prod = {{W{1'b0}}, x} * {{W{1'b0}}, RECIP};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x;
            qe_reg <= prod[2*W-1:W];
        end
    end

    // The remainder of the estimate is below twice the divisor, so seven bits hold it.
    assign diff = (W+7)'(x_reg) - (W+7)'(qe_reg) * (W+7)'(DIVISOR);
    assign rem  = diff[6:0];
    assign fix  = (rem >= 7'(DIVISOR));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= qe_reg + W'(fix);
            r_reg <= fix ? 6'(rem - 7'(DIVISOR)) : 6'(rem);
        end
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

`default_nettype wire

>>> src/todac_reduce.sv
// Amount reduction pipeline: turns an amount in a given unit into whole days
// and a remainder in hours, minutes and seconds over six stages.
// Depends on todac_pkg and todac_div_const.
`default_nettype none

module todac_reduce
    import todac_pkg::*;
#(
    parameter int unsigned AMOUNT_BITS = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  todac_cmd_t             in_cmd,
    input  logic [AMOUNT_BITS-1:0] in_amount,
    output logic                   out_valid,
    output todac_cmd_t             out_cmd,
    output todac_delta_t           out_delta
);

    localparam int unsigned STAGES = 6;

    logic [STAGES-1:0]      valid_reg;
    todac_cmd_t             cmd_reg [STAGES];
    logic [AMOUNT_BITS-1:0] amt_reg [4];
    logic [5:0]             ds_reg  [4];
    logic [5:0]             dm_reg  [2];

    logic [AMOUNT_BITS-1:0] q1, q2, q3;
    logic [5:0]             r1, r2, r3;
    logic [AMOUNT_BITS-1:0] x2, x3;

    // Seconds go through all three dividers, minutes skip the first, hours skip two.
    assign x2 = (cmd_reg[1].unit == UNIT_SEC) ? q1 : amt_reg[1];
    assign x3 = (cmd_reg[3].unit == UNIT_HOUR) ? amt_reg[3] : q2;

    todac_div_const #(.W(AMOUNT_BITS), .DIVISOR(SECS_PER_MIN)) u_div_sec (
        .clk (clk),
        .en  (en),
        .x   (in_amount),
        .q   (q1),
        .r   (r1)
    );

    todac_div_const #(.W(AMOUNT_BITS), .DIVISOR(MINS_PER_HOUR)) u_div_min (
        .clk (clk),
        .en  (en),
        .x   (x2),
        .q   (q2),
        .r   (r2)
    );

    todac_div_const #(.W(AMOUNT_BITS), .DIVISOR(HOURS_PER_DAY)) u_div_hour (
        .clk (clk),
        .en  (en),
        .x   (x3),
        .q   (q3),
        .r   (r3)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg[0] <= in_cmd;
            for (int k = 1; k < STAGES; k++)
            begin
                cmd_reg[k] <= cmd_reg[k-1];
            end

            amt_reg[0] <= in_amount;
            for (int k = 1; k < 4; k++)
            begin
                amt_reg[k] <= amt_reg[k-1];
            end

            ds_reg[0] <= (cmd_reg[1].unit == UNIT_SEC) ? r1 : 6'd0;
            for (int k = 1; k < 4; k++)
            begin
                ds_reg[k] <= ds_reg[k-1];
            end

            dm_reg[0] <= (cmd_reg[3].unit == UNIT_SEC || cmd_reg[3].unit == UNIT_MIN) ?
                         r2 : 6'd0;
            dm_reg[1] <= dm_reg[0];
        end
    end

    logic unit_valid;
    assign unit_valid = (cmd_reg[STAGES-1].unit == UNIT_SEC) ||
                        (cmd_reg[STAGES-1].unit == UNIT_MIN) ||
                        (cmd_reg[STAGES-1].unit == UNIT_HOUR);

    always_comb
    begin
        out_delta.second = ds_reg[3];
        out_delta.minute = dm_reg[1];
        out_delta.hour   = unit_valid ? 5'(r3) : 5'd0;
        if (!unit_valid)
        begin
            out_delta.days = 16'd0;
        end
        else if (33'(q3) > 33'(DAYS_MAX))
        begin
            out_delta.days = DAYS_MAX;
        end
        else
        begin
            out_delta.days = 16'(q3);
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_cmd   = cmd_reg[STAGES-1];

endmodule

`default_nettype wire

>>> src/todac_checker.sv
// Port-level checks for time_of_day_adjust_compare, attached by the bind below.
// Tracks the compare time from configuration transactions. Depends on todac_pkg.
`default_nettype none

module todac_checker
    import todac_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] days_crossed,
    input logic [4:0]  now_hour,
    input logic [5:0]  now_minute,
    input logic [5:0]  now_second,
    input logic [1:0]  order,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [5:0]  cfg_data
);

    logic [4:0] cmp_hour_reg;
    logic [5:0] cmp_minute_reg;
    logic [5:0] cmp_second_reg;
    logic       now_equal;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_hour_reg   <= '0;
            cmp_minute_reg <= '0;
            cmp_second_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COMPARE_HOUR:   cmp_hour_reg   <= 5'(cfg_data);
                REG_COMPARE_MINUTE: cmp_minute_reg <= cfg_data;
                REG_COMPARE_SECOND: cmp_second_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign now_equal = (now_hour == cmp_hour_reg) && (now_minute == cmp_minute_reg) &&
                       (now_second == cmp_second_reg);

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (now_hour < 5'd24) && (now_minute < 6'd60) && (now_second < 6'd60))
        else $error("response time out of range");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(days_crossed) && $stable(order) &&
            $stable(now_hour) && $stable(now_minute) && $stable(now_second))
        else $error("stalled response changed");

    a_equal_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((order == ORDER_EQUAL) == now_equal))
        else $error("equal order does not match compare time");

    a_before_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (order == ORDER_BEFORE) |-> (now_hour <= cmp_hour_reg))
        else $error("before order with a later hour");

endmodule

bind time_of_day_adjust_compare todac_checker u_todac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .days_crossed (rsp.days_crossed),
    .now_hour     (rsp.now_hour),
    .now_minute   (rsp.now_minute),
    .now_second   (rsp.now_second),
    .order        (rsp.order),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for time_of_day_adjust_compare.
// Uses todac_pkg and the channel interfaces in todac_if.sv; runs directed and
// random adjustments under several compare times and checks every response.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import todac_pkg::*;

    localparam int unsigned AMT_W        = 20;
    localparam int unsigned CLK_PERIOD   = 8;
    localparam int unsigned LATENCY      = 7;
    localparam int unsigned IDLE_PCT     = 31;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 138;
    localparam int unsigned LIMIT_CYCLES = 200000;

    localparam longint unsigned SECS_PER_HOUR = SECS_PER_MIN * MINS_PER_HOUR;
    localparam longint unsigned SECS_PER_DAY  = SECS_PER_HOUR * HOURS_PER_DAY;

    // The spare unit code carries no amount; the spare register index is ignored.
    localparam logic [1:0]       UNIT_NONE = 2'd3;
    localparam logic [1:0]       REG_SPARE = 2'd3;
    localparam logic [AMT_W-1:0] AMT_MAX   = '1;

    typedef struct packed {
        logic [1:0]       mode;
        logic [1:0]       unit;
        logic [AMT_W-1:0] amount;
        logic [4:0]       load_hour;
        logic [5:0]       load_minute;
        logic [5:0]       load_second;
    } adjust_t;

    typedef struct packed {
        logic [15:0] days;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [1:0]  order;
    } readout_t;

    typedef struct {
        adjust_t  cmd;
        bit       typed;
        readout_t want;
    } vector_t;

    logic clk = 1'b0;
    logic rst_n;

    todac_cmd_if #(.AMOUNT_BITS(AMT_W)) cmd_ch ();
    todac_rsp_if                        rsp_ch ();
    todac_cfg_if                        cfg_ch ();

    time_of_day_adjust_compare #(.AMOUNT_BITS(AMT_W)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow of the time of day and of the compare registers.
    logic [4:0] clk_hour   = '0;
    logic [5:0] clk_minute = '0;
    logic [5:0] clk_second = '0;
    logic [4:0] cmp_hour   = '0;
    logic [5:0] cmp_minute = '0;
    logic [5:0] cmp_second = '0;

    readout_t pending_readouts [$];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    bit steady = 1'b0;

    // Directed vectors start from midnight with the compare time at midnight.
    vector_t directed_vectors [25] = '{
        '{'{MODE_CLEAR, UNIT_SEC, 20'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd0, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_ADD, UNIT_SEC, 20'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd0, 5'd0, 6'd0, 6'd1, ORDER_AFTER}},
        '{'{MODE_SUB, UNIT_SEC, 20'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd0, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_SUB, UNIT_SEC, 20'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd1, 5'd23, 6'd59, 6'd59, ORDER_AFTER}},
        '{'{MODE_ADD, UNIT_SEC, 20'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd1, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_ADD, UNIT_HOUR, 20'd24, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd1, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_ADD, UNIT_MIN, 20'd1440, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd1, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_SUB, UNIT_SEC, 20'd86400, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd1, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_ADD, UNIT_HOUR, AMT_MAX, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd43690, 5'd15, 6'd0, 6'd0, ORDER_AFTER}},
        '{'{MODE_SUB, UNIT_HOUR, AMT_MAX, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd43690, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_ADD, UNIT_SEC, AMT_MAX, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd12, 5'd3, 6'd16, 6'd15, ORDER_AFTER}},
        '{'{MODE_SUB, UNIT_MIN, AMT_MAX, 5'd31, 6'd63, 6'd63}, 1'b0, '0},
        '{'{MODE_LOAD, UNIT_SEC, 20'd0, 5'd23, 6'd59, 6'd59}, 1'b1,
          '{16'd0, 5'd23, 6'd59, 6'd59, ORDER_AFTER}},
        '{'{MODE_LOAD, UNIT_HOUR, AMT_MAX, 5'd31, 6'd63, 6'd63}, 1'b1,
          '{16'd0, 5'd23, 6'd59, 6'd59, ORDER_AFTER}},
        '{'{MODE_LOAD, UNIT_SEC, 20'd0, 5'd24, 6'd60, 6'd60}, 1'b1,
          '{16'd0, 5'd23, 6'd59, 6'd59, ORDER_AFTER}},
        '{'{MODE_LOAD, UNIT_SEC, 20'd0, 5'd12, 6'd63, 6'd0}, 1'b1,
          '{16'd0, 5'd12, 6'd59, 6'd0, ORDER_AFTER}},
        '{'{MODE_LOAD, UNIT_SEC, 20'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd0, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_ADD, UNIT_NONE, AMT_MAX, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd0, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_SUB, UNIT_NONE, 20'd5, 5'd0, 6'd0, 6'd0}, 1'b1,
          '{16'd0, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_CLEAR, UNIT_NONE, AMT_MAX, 5'd31, 6'd63, 6'd63}, 1'b1,
          '{16'd0, 5'd0, 6'd0, 6'd0, ORDER_EQUAL}},
        '{'{MODE_ADD, UNIT_MIN, 20'd59, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
        '{'{MODE_ADD, UNIT_SEC, 20'd60, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
        '{'{MODE_SUB, UNIT_HOUR, 20'd1, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
        '{'{MODE_SUB, UNIT_MIN, 20'd1, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
        '{'{MODE_ADD, UNIT_SEC, 20'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0}
    };

    // Applies one adjustment to the shadow time and returns the response it causes.
    function automatic readout_t advance_clock(input adjust_t c);
        readout_t        r;
        longint unsigned scale;
        longint unsigned delta;
        longint unsigned now_s;
        longint unsigned total;
        longint unsigned gap;
        longint unsigned days;
        days  = 0;
        scale = (c.unit == UNIT_SEC)  ? 1 :
                (c.unit == UNIT_MIN)  ? SECS_PER_MIN :
                (c.unit == UNIT_HOUR) ? SECS_PER_HOUR : 0;
        delta = 64'(c.amount) * scale;
        now_s = (64'(clk_hour) * MINS_PER_HOUR + clk_minute) * SECS_PER_MIN + clk_second;
        total = now_s;
        case (c.mode)
            MODE_ADD:
            begin
                total = now_s + delta;
                days  = total / SECS_PER_DAY;
                total = total % SECS_PER_DAY;
            end
            MODE_SUB:
            begin
                if (delta <= now_s)
                begin
                    total = now_s - delta;
                end
                else
                begin
                    // Borrow whole days until the time is back on the clock face.
                    gap   = delta - now_s;
                    days  = (gap + SECS_PER_DAY - 1) / SECS_PER_DAY;
                    total = days * SECS_PER_DAY - gap;
                end
            end
            MODE_LOAD:
            begin
                if (c.load_hour < HOURS_PER_DAY)
                    clk_hour = c.load_hour;
                if (c.load_minute < MINS_PER_HOUR)
                    clk_minute = c.load_minute;
                if (c.load_second < SECS_PER_MIN)
                    clk_second = c.load_second;
            end
            MODE_CLEAR:
            begin
                clk_hour   = '0;
                clk_minute = '0;
                clk_second = '0;
            end
        endcase
        if (c.mode == MODE_ADD || c.mode == MODE_SUB)
        begin
            clk_second = 6'(total % SECS_PER_MIN);
            clk_minute = 6'((total / SECS_PER_MIN) % MINS_PER_HOUR);
            clk_hour   = 5'(total / SECS_PER_HOUR);
        end
        r.days   = (days > DAYS_MAX) ? DAYS_MAX : 16'(days);
        r.hour   = clk_hour;
        r.minute = clk_minute;
        r.second = clk_second;
        // Hour, minute and second side by side order the same way as the fields in turn.
        if ({clk_hour, clk_minute, clk_second} < {cmp_hour, cmp_minute, cmp_second})
            r.order = ORDER_BEFORE;
        else if ({clk_hour, clk_minute, clk_second} == {cmp_hour, cmp_minute, cmp_second})
            r.order = ORDER_EQUAL;
        else
            r.order = ORDER_AFTER;
        return r;
    endfunction

    function automatic adjust_t random_adjust();
        adjust_t     c;
        int unsigned pick;
        pick   = $urandom_range(99);
        c.mode = (pick < 36) ? MODE_ADD : (pick < 72) ? MODE_SUB :
                 (pick < 92) ? MODE_LOAD : MODE_CLEAR;
        pick   = $urandom_range(99);
        c.unit = (pick < 6) ? UNIT_NONE : (pick < 40) ? UNIT_SEC :
                 (pick < 72) ? UNIT_MIN : UNIT_HOUR;
        pick   = $urandom_range(99);
        if (pick < 45)
            c.amount = AMT_W'($urandom_range(120));
        else if (pick < 75)
            c.amount = AMT_W'($urandom_range(100000));
        else if (pick < 95)
            c.amount = AMT_W'($urandom);
        else
            c.amount = pick[0] ? AMT_MAX : '0;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            c.load_hour   = 5'($urandom_range(23));
            c.load_minute = 6'($urandom_range(59));
            c.load_second = 6'($urandom_range(59));
        end
        else if (pick < 75)
        begin
            // Land on or next to the compare time so that every order shows up.
            c.load_hour   = cmp_hour;
            c.load_minute = cmp_minute;
            c.load_second = cmp_second + 6'($urandom_range(2)) - 6'd1;
        end
        else
        begin
            c.load_hour   = 5'($urandom_range(31));
            c.load_minute = 6'($urandom_range(63));
            c.load_second = 6'($urandom_range(63));
        end
        return c;
    endfunction

    task automatic send_adjust(input adjust_t c, input bit typed, input readout_t want);
        readout_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= c.mode;
        cmd_ch.unit        <= c.unit;
        cmd_ch.amount      <= c.amount;
        cmd_ch.load_hour   <= c.load_hour;
        cmd_ch.load_minute <= c.load_minute;
        cmd_ch.load_second <= c.load_second;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = advance_clock(c);
        pending_readouts.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_COMPARE_HOUR:   cmp_hour   = value[4:0];
            REG_COMPARE_MINUTE: cmp_minute = value;
            REG_COMPARE_SECOND: cmp_second = value;
            default:            ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge clk)
    begin
        readout_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_readouts.size() == 0)
            begin
                $display("%0t: response with nothing expected, expected none, got %0d %0d:%0d:%0d %0d",
                         $time, rsp_ch.days_crossed, rsp_ch.now_hour, rsp_ch.now_minute,
                         rsp_ch.now_second, rsp_ch.order);
                fault_count++;
            end
            else
            begin
                want = pending_readouts.pop_front();
                check_field("days_crossed", 16'(want.days), 16'(rsp_ch.days_crossed));
                check_field("now_hour", 16'(want.hour), 16'(rsp_ch.now_hour));
                check_field("now_minute", 16'(want.minute), 16'(rsp_ch.now_minute));
                check_field("now_second", 16'(want.second), 16'(rsp_ch.now_second));
                check_field("order", 16'(want.order), 16'(rsp_ch.order));
            end
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int unsigned ph;
        int unsigned n;
        logic [5:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.mode        <= MODE_ADD;
        cmd_ch.unit        <= UNIT_SEC;
        cmd_ch.amount      <= '0;
        cmd_ch.load_hour   <= '0;
        cmd_ch.load_minute <= '0;
        cmd_ch.load_second <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_COMPARE_HOUR;
        cfg_ch.data        <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_vectors[i])
            send_adjust(directed_vectors[i].cmd, directed_vectors[i].typed,
                        directed_vectors[i].want);

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:       {set_hour, set_minute, set_second} = {6'd23, 6'd59, 6'd59};
                1:       {set_hour, set_minute, set_second} = {6'd63, 6'd63, 6'd63};
                2:       {set_hour, set_minute, set_second} = {6'd0, 6'd0, 6'd0};
                3:       {set_hour, set_minute, set_second} = {6'd12, 6'd30, 6'd30};
                default:
                begin
                    set_hour   = 6'($urandom_range(63));
                    set_minute = 6'($urandom_range(63));
                    set_second = 6'($urandom_range(63));
                end
            endcase
            write_reg(REG_COMPARE_HOUR, set_hour);
            write_reg(REG_COMPARE_MINUTE, set_minute);
            write_reg(REG_COMPARE_SECOND, set_second);
            if (ph == 5)
                write_reg(REG_SPARE, 6'($urandom_range(63)));
            // One phase runs with neither side idling.
            steady = (ph == 4);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    wait_idle();
                send_adjust(random_adjust(), 1'b0, '0);
            end
        end

        steady = 1'b0;
        wait_idle();
        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
